@@ rtl/fpsq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fpsq_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    localparam int SHIFT_W = 6;

    localparam logic [SHIFT_W-1:0] FRAC_SHIFT_RESET = SHIFT_W'(16);

    typedef struct packed {
        logic valid;
        logic zero;
    } fpsq_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/fpsq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fpsq_cell #(
    parameter int DATA_WIDTH = fpsq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     advance,
    input  wire fpsq_pkg::fpsq_ctrl_t     ctrl_in,
    input  wire logic [2*DATA_WIDTH-1:0]  rad_in,
    input  wire logic [DATA_WIDTH+1:0]    rem_in,
    input  wire logic [DATA_WIDTH-1:0]    q_in,
    output fpsq_pkg::fpsq_ctrl_t          ctrl_out,
    output logic [2*DATA_WIDTH-1:0]       rad_out,
    output logic [DATA_WIDTH+1:0]         rem_out,
    output logic [DATA_WIDTH-1:0]         q_out
);

    fpsq_pkg::fpsq_ctrl_t          ctrl_reg;
    logic [2*DATA_WIDTH-1:0]       rad_reg;
    logic [DATA_WIDTH+1:0]         rem_reg;
    logic [DATA_WIDTH-1:0]         q_reg;

    logic [DATA_WIDTH+1:0]         rem_shift;
    logic [DATA_WIDTH+1:0]         trial;
    logic                          take;
    logic [2*DATA_WIDTH-1:0]       rad_next;
    logic [DATA_WIDTH+1:0]         rem_next;
    logic [DATA_WIDTH-1:0]         q_next;

    // bring down the next radicand digit pair and try the next root bit
    assign rem_shift = {rem_in[DATA_WIDTH-1:0], rad_in[2*DATA_WIDTH-1 -: 2]};
    assign trial     = {q_in, 2'b01};
    assign take      = (rem_shift >= trial);
    assign rem_next  = take ? (rem_shift - trial) : rem_shift;
    assign q_next    = {q_in[DATA_WIDTH-2:0], take};
    assign rad_next  = {rad_in[2*DATA_WIDTH-3:0], 2'b00};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (advance) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rad_reg <= rad_next;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign q_out    = q_reg;

endmodule

`default_nettype wire

@@ rtl/fixed_point_square_root.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  s_tdata: radicand
// m_        out        m_tvalid / m_tready  m_tdata: root
// cfg_      in         cfg_valid / cfg_ready cfg_data: frac_shift
//
// The chain has one registered cell per root bit.
// The chain takes a new radicand every cycle while the result side keeps up.
// A stalled result holds the whole chain; s_tready follows it.
// Reset clears the valid bits of the chain and sets frac_shift to 16.

module fixed_point_square_root #(
    parameter int DATA_WIDTH = fpsq_pkg::DATA_WIDTH_DEF,
    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [TDATA_W-1:0]            s_tdata,   // [DATA_WIDTH-1:0] radicand
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [TDATA_W-1:0]                 m_tdata,   // [DATA_WIDTH-1:0] root
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fpsq_pkg::SHIFT_W-1:0]  cfg_data   // frac_shift
);

    logic [fpsq_pkg::SHIFT_W-1:0]  frac_shift_reg;
    logic [fpsq_pkg::SHIFT_W-1:0]  shift_sat;
    logic [DATA_WIDTH-1:0]         radicand;
    logic                          advance;
    logic [DATA_WIDTH-1:0]         root;

    fpsq_pkg::fpsq_ctrl_t          ctrl_w [0:DATA_WIDTH];
    logic [2*DATA_WIDTH-1:0]       rad_w  [0:DATA_WIDTH];
    logic [DATA_WIDTH+1:0]         rem_w  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0]         q_w    [0:DATA_WIDTH];
    logic [DATA_WIDTH:1]           stage_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_shift_reg <= fpsq_pkg::FRAC_SHIFT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            frac_shift_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // saturate the shift so the scaled value stays within twice the width
    assign shift_sat = (frac_shift_reg > fpsq_pkg::SHIFT_W'(DATA_WIDTH))
                     ? fpsq_pkg::SHIFT_W'(DATA_WIDTH) : frac_shift_reg;

    assign radicand = s_tdata[DATA_WIDTH-1:0];
    assign advance  = !ctrl_w[DATA_WIDTH].valid || m_tready;
    assign s_tready = advance;

    assign ctrl_w[0].valid = s_tvalid;
    assign ctrl_w[0].zero  = (radicand == '0);
    assign rad_w[0]        = {{DATA_WIDTH{1'b0}}, radicand} << shift_sat;
    assign rem_w[0]        = '0;
    assign q_w[0]          = '0;

    for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
        fpsq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .ctrl_in  (ctrl_w[i]),
            .rad_in   (rad_w[i]),
            .rem_in   (rem_w[i]),
            .q_in     (q_w[i]),
            .ctrl_out (ctrl_w[i+1]),
            .rad_out  (rad_w[i+1]),
            .rem_out  (rem_w[i+1]),
            .q_out    (q_w[i+1])
        );
        assign stage_valid[i+1] = ctrl_w[i+1].valid;
    end

    assign root     = ctrl_w[DATA_WIDTH].zero ? {DATA_WIDTH{1'b1}} : q_w[DATA_WIDTH];
    assign m_tvalid = ctrl_w[DATA_WIDTH].valid;
    assign m_tdata  = TDATA_W'(root);

    a_chain_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(stage_valid))
        else $error("chain moved while the result was stalled");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !ctrl_w[DATA_WIDTH].zero)
            |-> (rem_w[DATA_WIDTH] <= {1'b0, q_w[DATA_WIDTH], 1'b0}))
        else $error("final remainder exceeds twice the root");

    a_root_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !ctrl_w[DATA_WIDTH].zero) |-> (q_w[DATA_WIDTH] != '0))
        else $error("nonzero radicand gave a zero root");

endmodule

`default_nettype wire
